// ===== hdl/igpf_pkg.sv =====
// ----------------------------------------------------------------------------
// igpf_pkg
// Shared types and constants of the idle-gap packet framer: operation codes,
// register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package igpf_pkg;

	// Default number of byte slots in each bank
	localparam int DEF_BUFFER_DEPTH = 256;

	// Field widths
	localparam int OP_W     = 2;
	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 8;
	localparam int LEN_W    = 9;
	localparam int TICKS_W  = 16;

	// Configuration port geometry
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = CFG_ADDR_W - 2;

	// Register reset values
	localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 16'd20;
	localparam logic [LEN_W-1:0]   MIN_LENGTH_RESET = 9'd3;

	// Operation codes carried by a request beat
	typedef enum logic [OP_W-1:0] {
		OP_BYTE    = 2'd0,
		OP_TICK    = 2'd1,
		OP_READ    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	// Register indexes (byte address divided by four)
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IDLE_TICKS = 1'd0,
		REG_MIN_LENGTH = 1'd1
	} reg_index_t;

	// Configuration handed from the register block to the datapath
	typedef struct packed {
		logic [TICKS_W-1:0] idle_ticks;
		logic [LEN_W-1:0]   min_length;
	} cfg_t;

endpackage

// ===== hdl/igpf_if.sv =====
// ----------------------------------------------------------------------------
// igpf_in_if / igpf_out_if
// Valid/ready channels of the framer: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface igpf_in_if;
	import igpf_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [BYTE_W-1:0]   rx_byte;
	logic [INDEX_W-1:0]  read_index;

	modport source (output valid, output operation, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input operation, input rx_byte, input read_index,
		output ready);
endinterface

interface igpf_out_if;
	import igpf_pkg::*;

	logic               valid;
	logic               ready;
	logic [BYTE_W-1:0]  read_data;
	logic               packet_ready;
	logic               overflow;
	logic [LEN_W-1:0]   packet_length;
	logic               packet_done;
	logic [LEN_W-1:0]   fill_length;

	modport source (output valid, output read_data, output packet_ready, output overflow,
		output packet_length, output packet_done, output fill_length, input ready);
	modport sink (input valid, input read_data, input packet_ready, input overflow,
		input packet_length, input packet_done, input fill_length, output ready);
endinterface

// ===== hdl/igpf_ram.sv =====
// ----------------------------------------------------------------------------
// igpf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when enabled.
// ----------------------------------------------------------------------------
module igpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/igpf_cfg.sv =====
// ----------------------------------------------------------------------------
// igpf_cfg
// APB-style register block: idle threshold and minimum packet length.
// ----------------------------------------------------------------------------
module igpf_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [igpf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [igpf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [igpf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready,
	output igpf_pkg::cfg_t                   cfg
);
	import igpf_pkg::*;

	cfg_t                   cfg_q;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] index;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign index  = paddr[CFG_ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_ticks <= IDLE_TICKS_RESET;
			cfg_q.min_length <= MIN_LENGTH_RESET;
		end else if (wr_en) begin
			case (index)
				REG_IDLE_TICKS: cfg_q.idle_ticks <= pwdata[TICKS_W-1:0];
				REG_MIN_LENGTH: cfg_q.min_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (index)
			REG_IDLE_TICKS: prdata = CFG_DATA_W'(cfg_q.idle_ticks);
			REG_MIN_LENGTH: prdata = CFG_DATA_W'(cfg_q.min_length);
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== hdl/idle_gap_packet_framer.sv =====
// ----------------------------------------------------------------------------
// idle_gap_packet_framer
// Frames received serial bytes into packets by idle gaps, using two banks.
//
// Usage:
//   req carries one operation per beat: a received byte, a tick of the time
//   base, a read of a packet byte, or a release of the stored packet. rsp
//   returns one result beat per request beat with the flags and lengths as
//   they stand after that operation, plus the byte for a read.
//   Each beat is decided in the cycle it is taken; its result appears in
//   the next cycle, from the single registered read of the packet bank. One
//   beat per cycle is sustained: a closed packet costs no copy, since the
//   receive and packet banks swap roles by flipping a select bit.
//   When rsp stalls, the result register holds and req.ready drops until
//   the held beat is taken; a new beat enters in the cycle the held one
//   leaves. After reset the fill, idle count, lengths and flags are zero
//   and both registers are at their defaults; bank contents are not
//   cleared, and only written slots are ever read back. Registers sit on
//   an APB-style port at byte addresses 0 (idle ticks) and 4 (min length).
// ----------------------------------------------------------------------------
module idle_gap_packet_framer #(
	parameter int BUFFER_DEPTH = igpf_pkg::DEF_BUFFER_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	igpf_in_if.sink                          req,
	igpf_out_if.source                       rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [igpf_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [igpf_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [igpf_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import igpf_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int FW = $clog2(BUFFER_DEPTH + 1);
	localparam int CW = (FW > LEN_W) ? FW : LEN_W;

	cfg_t cfg;

	// Architectural state
	logic [FW-1:0]      fill_q;
	logic [TICKS_W-1:0] idle_q;
	logic [FW-1:0]      stored_q;
	logic               ready_q;
	logic               ovf_q;
	logic               bank_sel_q;

	// Next state
	logic [FW-1:0]      fill_d;
	logic [TICKS_W-1:0] idle_d;
	logic [FW-1:0]      stored_d;
	logic               ready_d;
	logic               ovf_d;
	logic               bank_sel_d;
	logic               done_d;

	// Result stage
	logic               valid_s1;
	logic               hit_s1;
	logic               bank_s1;
	logic               ready_s1;
	logic               ovf_s1;
	logic [FW-1:0]      stored_s1;
	logic               done_s1;
	logic [FW-1:0]      fill_s1;

	logic               accept;
	logic               advance;
	op_t                op;
	logic               at_gap;
	logic [LEN_W-1:0]   least;
	logic [FW-1:0]      base;
	logic [FW-1:0]      slot;
	logic [CW-1:0]      idx_ext;
	logic               rd_hit;
	logic               swap;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic               we0, we1, re0, re1;
	logic [BYTE_W-1:0]  rdata0, rdata1;
	logic [CW-1:0]      stored_ext_s1;
	logic [CW-1:0]      fill_ext_s1;

	igpf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the result stage when it is empty or being drained
	assign advance   = !valid_s1 || rsp.ready;
	assign req.ready = advance;
	assign accept    = req.valid && advance;
	assign op        = op_t'(req.operation);

	// Operation decode and state update
	always_comb begin
		at_gap     = idle_q >= cfg.idle_ticks;
		least      = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
		base       = at_gap ? '0 : fill_q;
		slot       = (base >= FW'(BUFFER_DEPTH - 1)) ? FW'(BUFFER_DEPTH - 1) : base;
		idx_ext    = CW'(req.read_index);
		rd_hit     = (idx_ext < CW'(stored_q)) && (idx_ext < CW'(BUFFER_DEPTH));
		swap       = 1'b0;
		fill_d     = fill_q;
		idle_d     = idle_q;
		stored_d   = stored_q;
		ready_d    = ready_q;
		ovf_d      = ovf_q;
		bank_sel_d = bank_sel_q;
		done_d     = 1'b0;
		case (op)
			OP_BYTE: begin
				idle_d = '0;
				fill_d = slot + FW'(1);
			end
			OP_TICK: begin
				if (!at_gap) begin
					idle_d = idle_q + TICKS_W'(1);
				end else if (CW'(fill_q) >= CW'(least)) begin
					swap       = 1'b1;
					ovf_d      = ovf_q || ready_q;
					stored_d   = fill_q;
					ready_d    = 1'b1;
					fill_d     = '0;
					bank_sel_d = !bank_sel_q;
					done_d     = 1'b1;
				end
			end
			OP_RELEASE: begin
				ready_d = 1'b0;
				ovf_d   = 1'b0;
			end
			default: ;
		endcase
	end

	// Bank ports: bytes land in the receive bank, reads hit the packet bank
	assign waddr = slot[AW-1:0];
	assign raddr = idx_ext[AW-1:0];
	assign we0   = accept && (op == OP_BYTE) && !bank_sel_q;
	assign we1   = accept && (op == OP_BYTE) &&  bank_sel_q;
	assign re0   = accept && (op == OP_READ) &&  bank_sel_q;
	assign re1   = accept && (op == OP_READ) && !bank_sel_q;

	igpf_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (req.rx_byte),
		.re    (re0),
		.raddr (raddr),
		.rdata (rdata0)
	);

	igpf_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (req.rx_byte),
		.re    (re1),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// Commit state on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			idle_q     <= '0;
			stored_q   <= '0;
			ready_q    <= 1'b0;
			ovf_q      <= 1'b0;
			bank_sel_q <= 1'b0;
		end else if (accept) begin
			fill_q     <= fill_d;
			idle_q     <= idle_d;
			stored_q   <= stored_d;
			ready_q    <= ready_d;
			ovf_q      <= ovf_d;
			bank_sel_q <= bank_sel_d;
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= req.valid;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1    <= (op == OP_READ) && rd_hit;
			bank_s1   <= !bank_sel_q;
			ready_s1  <= ready_d;
			ovf_s1    <= ovf_d;
			stored_s1 <= stored_d;
			done_s1   <= done_d;
			fill_s1   <= fill_d;
		end
	end

	// Drive the result beat
	assign stored_ext_s1     = CW'(stored_s1);
	assign fill_ext_s1       = CW'(fill_s1);
	assign rsp.valid         = valid_s1;
	assign rsp.read_data     = hit_s1 ? (bank_s1 ? rdata1 : rdata0) : '0;
	assign rsp.packet_ready  = ready_s1;
	assign rsp.overflow      = ovf_s1;
	assign rsp.packet_length = stored_ext_s1[LEN_W-1:0];
	assign rsp.packet_done   = done_s1;
	assign rsp.fill_length   = fill_ext_s1[LEN_W-1:0];

	// Overflow is only ever raised on top of a ready packet
	a_ovf_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> ready_q)
		else $error("overflow set without a ready packet");

	// Fill never passes the bank depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= CW'(BUFFER_DEPTH))
		else $error("fill count beyond bank depth");

	// Banks swap exactly when a packet closes
	a_swap_flip: assert property (@(posedge clk) disable iff (!arst_n)
		accept && swap |=> bank_sel_q != $past(bank_sel_q))
		else $error("bank select did not flip on packet close");

	// A stored byte leaves a nonempty fill
	a_byte_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_BYTE) |=> fill_q != '0)
		else $error("fill empty after a received byte");

	// A closed packet is reported as ready
	a_done_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.packet_done |-> rsp.packet_ready && (stored_s1 != '0))
		else $error("closed packet not flagged ready");

endmodule
